// ----- hw/rtl/hsvle_pkg.sv -----
// Shared types and constants for the HSV pixel to LED SPI encoder.
// No dependencies; imported by every module of the block.
package hsvle_pkg;

	// queue between the color front end and the byte serializer
	localparam int QUEUE_DEPTH_DEF = 4;

	// configuration register file
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PAT_00 = 2'd0;
	localparam cfg_idx_t REG_PAT_01 = 2'd1;
	localparam cfg_idx_t REG_PAT_10 = 2'd2;
	localparam cfg_idx_t REG_PAT_11 = 2'd3;

	localparam logic [7:0] PAT_00_RST = 8'd136;
	localparam logic [7:0] PAT_01_RST = 8'd142;
	localparam logic [7:0] PAT_10_RST = 8'd232;
	localparam logic [7:0] PAT_11_RST = 8'd238;

	// color bit pair codes
	localparam logic [1:0] PAIR_00 = 2'b00;
	localparam logic [1:0] PAIR_01 = 2'b01;
	localparam logic [1:0] PAIR_10 = 2'b10;
	localparam logic [1:0] PAIR_11 = 2'b11;

	// hue sectors
	localparam logic [1:0] SECTOR_0 = 2'd0;
	localparam logic [1:0] SECTOR_1 = 2'd1;
	localparam logic [1:0] SECTOR_2 = 2'd2;

	// hue scale factor (192/256)
	localparam logic [7:0] HUE_SCALE = 8'd192;

	// twelve SPI bytes per pixel
	localparam int BYTE_CNT_W = 4;
	localparam logic [BYTE_CNT_W-1:0] LAST_BYTE_IDX = 4'd11;

	typedef struct packed {
		logic       we;
		cfg_idx_t   index;
		logic [7:0] data;
	} cfg_wr_t;

	// colors in transmit order
	typedef struct packed {
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] b;
	} rgb_t;

endpackage

// ----- hw/rtl/hsv_pixel_to_led_spi_encoder_top.sv -----
// Top level of the HSV pixel to LED SPI encoder.
// Depends on hsvle_pkg, hsvle_front, hsvle_fifo and hsvle_back.
//
// Usage:
//   Input channel (in_valid / in_stall, hue, sat, brightness) takes one HSV
//   pixel per transfer. Output channel (out_valid / out_stall, spi_byte,
//   last_byte) returns twelve SPI bytes per pixel: G, R, B, four bytes each,
//   top bit pair first; last_byte marks the twelfth.
//   cfg_we / cfg_index / cfg_data write the four pattern bytes; write them
//   only while the block is idle.
//   A pixel sent to an empty block enters the first color stage at its transfer
//   edge, then passes two more color stages, the queue, the serializer and the
//   output register, where out_valid rises for its first byte.
//   Throughput: one output byte per cycle while the receiver does not stall,
//   set by the serializer. The front end takes one pixel per cycle until
//   the queue (QUEUE_DEPTH entries) is full while a pixel waits in its last stage.
//   Reset clears all pipelines and the queue and loads the default pattern
//   bytes. When the receiver stalls, the output byte holds, the serializer
//   waits, and back-pressure reaches in_stall once the queue fills.
module hsv_pixel_to_led_spi_encoder_top import hsvle_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     hue,
	input  logic [7:0]     sat,
	input  logic [7:0]     brightness,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     spi_byte,
	output logic           last_byte,
	input  logic           cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]     cfg_data
);

	logic    push, full, pop, empty;
	rgb_t    push_data, pop_data;
	cfg_wr_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	hsvle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.hue        (hue),
		.sat        (sat),
		.brightness (brightness),
		.in_stall   (in_stall),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	hsvle_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	hsvle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.spi_byte  (spi_byte),
		.last_byte (last_byte)
	);

endmodule

// ----- hw/rtl/hsvle_front.sv -----
// Color front end: three-stage HSV to RGB pipeline feeding the queue.
// Depends on hsvle_pkg.
module hsvle_front import hsvle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] hue,
	input  logic [7:0] sat,
	input  logic [7:0] brightness,
	output logic       in_stall,
	output logic       push,
	output rgb_t       push_data,
	input  logic       full
);

	logic       valid_s1, valid_s2, valid_s3;
	logic       adv;
	logic [15:0] hue_prod;
	logic [13:0] rise_prod;
	logic [7:0] rise_c;
	logic [15:0] base_prod, rise_sc_prod, fall_sc_prod;

	logic [1:0] sector_s1, sector_s2, sector_s3;
	logic [5:0] offset_s1;
	logic [7:0] sat_s1, val_s1;
	logic [7:0] base_s2, rise_s2, fall_s2, val_s2;
	logic [7:0] base_s3, rise_s3, fall_s3;

	// whole pipeline moves unless the last stage is blocked by a full queue
	assign adv      = !(valid_s3 && full);
	assign in_stall = !adv;
	assign push     = valid_s3 && !full;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1: scale hue to 0..191, split into sector and offset
	assign hue_prod = hue * HUE_SCALE;

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= hue_prod[15:14];
			offset_s1 <= hue_prod[13:8];
			sat_s1    <= sat;
			val_s1    <= brightness;
		end
	end

	// s2: base, rise and fall levels; rise = offset * sat / 64
	assign rise_prod = offset_s1 * sat_s1;
	assign rise_c    = rise_prod[13:6];

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s2 <= sector_s1;
			base_s2   <= ~sat_s1;
			rise_s2   <= rise_c;
			fall_s2   <= sat_s1 - rise_c;
			val_s2    <= val_s1;
		end
	end

	// s3: scale each level by brightness / 256, truncating
	assign base_prod    = base_s2 * val_s2;
	assign rise_sc_prod = rise_s2 * val_s2;
	assign fall_sc_prod = fall_s2 * val_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s3 <= sector_s2;
			base_s3   <= base_prod[15:8];
			rise_s3   <= rise_sc_prod[15:8];
			fall_s3   <= fall_sc_prod[15:8];
		end
	end

	// per-sector mix into the queue entry; unused sector gives plain base
	always_comb begin
		push_data.r = base_s3;
		push_data.g = base_s3;
		push_data.b = base_s3;
		unique case (sector_s3)
			SECTOR_0: begin
				push_data.r = base_s3 + fall_s3;
				push_data.g = base_s3 + rise_s3;
			end
			SECTOR_1: begin
				push_data.g = base_s3 + fall_s3;
				push_data.b = base_s3 + rise_s3;
			end
			SECTOR_2: begin
				push_data.r = base_s3 + rise_s3;
				push_data.b = base_s3 + fall_s3;
			end
			default: begin
				push_data.r = base_s3;
			end
		endcase
	end

endmodule

// ----- hw/rtl/hsvle_fifo.sv -----
// Small synchronous queue of RGB entries between front end and serializer.
// Depends on hsvle_pkg.
module hsvle_fifo import hsvle_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rgb_t push_data,
	output logic full,
	input  logic pop,
	output rgb_t pop_data,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rgb_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers wrap at the last entry; fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// a pop without push drains exactly one entry
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not drop on pop");

endmodule

// ----- hw/rtl/hsvle_back.sv -----
// Byte serializer: turns each queued RGB entry into twelve SPI pattern bytes
// and holds the pattern registers. Depends on hsvle_pkg.
module hsvle_back import hsvle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	output logic       pop,
	input  rgb_t       pop_data,
	input  logic       empty,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] spi_byte,
	output logic       last_byte
);

	logic [7:0]            pat_00_q, pat_01_q, pat_10_q, pat_11_q;
	logic [23:0]           word_q;
	logic                  have_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic                  out_valid_q, last_byte_q;
	logic [7:0]            spi_byte_q;
	logic                  emit, last_now;
	logic [7:0]            pat_sel;

	// pattern registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_00_q <= PAT_00_RST;
			pat_01_q <= PAT_01_RST;
			pat_10_q <= PAT_10_RST;
			pat_11_q <= PAT_11_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_PAT_00: pat_00_q <= cfg.data;
				REG_PAT_01: pat_01_q <= cfg.data;
				REG_PAT_10: pat_10_q <= cfg.data;
				REG_PAT_11: pat_11_q <= cfg.data;
				default:    pat_00_q <= pat_00_q;
			endcase
		end
	end

	// a byte goes out whenever the output register is free or draining
	assign emit     = have_q && (!out_valid_q || !out_stall);
	assign last_now = cnt_q == LAST_BYTE_IDX;
	assign pop      = !empty && (!have_q || (emit && last_now));

	// pattern lookup for the top bit pair of the current word
	always_comb begin
		unique case (word_q[23:22])
			PAIR_00: pat_sel = pat_00_q;
			PAIR_01: pat_sel = pat_01_q;
			PAIR_10: pat_sel = pat_10_q;
			PAIR_11: pat_sel = pat_11_q;
			default: pat_sel = pat_00_q;
		endcase
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			have_q <= 1'b1;
			cnt_q  <= '0;
		end else if (emit) begin
			if (last_now) begin
				have_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// color word: G, R, B, shifted out two bits at a time
	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= pop_data;
		end else if (emit) begin
			word_q <= {word_q[21:0], 2'b00};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			spi_byte_q  <= pat_sel;
			last_byte_q <= last_now;
		end
	end

	assign out_valid = out_valid_q;
	assign spi_byte  = spi_byte_q;
	assign last_byte = last_byte_q;

	// no gap inside a pixel once a byte has been taken
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !last_byte_q) |=> out_valid_q)
		else $error("gap inside a pixel's byte train");

	// the final byte leaves the counter rewound
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_byte_q) |-> (cnt_q == '0))
		else $error("byte counter not rewound after last byte");

	// counter idles at zero without a word
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (cnt_q == '0))
		else $error("byte counter moved without a word");

endmodule

// ----- dv/hsv_pixel_to_led_spi_encoder_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for hsv_pixel_to_led_spi_encoder_top: a directed pixel table, then
// random pixels under several pattern byte settings, with random idling on both channels.
// Depends on hsvle_pkg and the encoder RTL; every SPI byte is checked against a local model.
module hsv_pixel_to_led_spi_encoder_top_tb;
	import hsvle_pkg::*;

	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 6;
	localparam int PHASE_PIXELS = 25;
	localparam int DIR_ROWS     = 18;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       last_byte;
	} spi_beat_t;

	// directed row: colors are used as given when known is set
	typedef struct {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] brightness;
		bit         known;
		rgb_t       colors;
	} pixel_row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid;
	logic           in_stall;
	logic [7:0]     hue;
	logic [7:0]     sat;
	logic [7:0]     brightness;
	logic           out_valid;
	logic           out_stall;
	logic [7:0]     spi_byte;
	logic           last_byte;
	logic           cfg_we;
	cfg_idx_t       cfg_index;
	logic [7:0]     cfg_data;

	// local copy of the pattern registers, indexed by color bit pair
	logic [7:0]     pair_byte [4];
	spi_beat_t      spi_beats_due [$];
	int             fail_count = 0;
	int             idle_cycles = 0;
	int             in_gap_max = 5;
	int             out_stall_max = 5;
	bit             hold_req = 1'b0;

	pixel_row_t pixel_rows [DIR_ROWS] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, 24'h000000},
		'{8'd0,   8'd255, 8'd255, 1'b1, 24'h00FE00},
		'{8'd0,   8'd0,   8'd255, 1'b1, 24'hFEFEFE},
		'{8'd255, 8'd255, 8'd0,   1'b1, 24'h000000},
		'{8'd128, 8'd200, 8'd0,   1'b1, 24'h000000},
		'{8'd255, 8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd85,  8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd86,  8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd170, 8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd171, 8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd1,   8'd255, 8'd255, 1'b0, 24'h0},
		'{8'd254, 8'd254, 8'd254, 1'b0, 24'h0},
		'{8'd127, 8'd127, 8'd127, 1'b0, 24'h0},
		'{8'd42,  8'd200, 8'd100, 1'b0, 24'h0},
		'{8'd85,  8'd0,   8'd255, 1'b0, 24'h0},
		'{8'd86,  8'd1,   8'd1,   1'b0, 24'h0},
		'{8'd170, 8'd170, 8'd255, 1'b0, 24'h0},
		'{8'd43,  8'd255, 8'd128, 1'b0, 24'h0}
	};

	hsv_pixel_to_led_spi_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.sat        (sat),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.spi_byte   (spi_byte),
		.last_byte  (last_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// level * brightness / 256, truncated
	function automatic logic [7:0] scale_level(input logic [7:0] level, input logic [7:0] factor);
		logic [15:0] prod;
		prod = level * factor;
		return prod[15:8];
	endfunction

	// three-sector HSV to color, returned in transmit order
	function automatic rgb_t hsv_to_grb(input logic [7:0] h_in, input logic [7:0] s_in,
			input logic [7:0] v_in);
		logic [15:0] hue_prod;
		logic [15:0] rise_prod;
		logic [7:0]  h_scaled;
		logic [1:0]  sector;
		logic [5:0]  offset;
		logic [7:0]  rise;
		logic [7:0]  fall;
		logic [7:0]  base_v;
		logic [7:0]  rise_v;
		logic [7:0]  fall_v;
		rgb_t        c;
		hue_prod  = h_in * HUE_SCALE;
		h_scaled  = hue_prod[15:8];
		sector    = h_scaled[7:6];
		offset    = h_scaled[5:0];
		rise_prod = {offset, 2'b00} * s_in;
		rise      = rise_prod[15:8];
		fall      = s_in - rise;
		base_v    = scale_level(8'd255 - s_in, v_in);
		rise_v    = scale_level(rise, v_in);
		fall_v    = scale_level(fall, v_in);
		c = {base_v, base_v, base_v};
		case (sector)
			SECTOR_0: begin
				c.r = base_v + fall_v;
				c.g = base_v + rise_v;
			end
			SECTOR_1: begin
				c.g = base_v + fall_v;
				c.b = base_v + rise_v;
			end
			SECTOR_2: begin
				c.r = base_v + rise_v;
				c.b = base_v + fall_v;
			end
			default: ;
		endcase
		return c;
	endfunction

	// twelve SPI bytes per pixel, top bit pair of G first
	function automatic void queue_pixel_bytes(input rgb_t c);
		logic [23:0] bits;
		logic [1:0]  pair;
		spi_beat_t   beat;
		bits = c;
		for (int k = 0; k < 12; k++) begin
			pair = bits[23 - 2 * k -: 2];
			beat.spi_byte  = pair_byte[pair];
			beat.last_byte = (k == LAST_BYTE_IDX);
			spi_beats_due.push_back(beat);
		end
	endfunction

	// offer one pixel after a gap, return at its transfer
	task automatic send_pixel(input logic [7:0] h_in, input logic [7:0] s_in,
			input logic [7:0] v_in, input rgb_t colors, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		hue        <= h_in;
		sat        <= s_in;
		brightness <= v_in;
		do @(posedge clk); while (in_stall);
		queue_pixel_bytes(colors);
	endtask

	task automatic write_pattern(input cfg_idx_t idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		pair_byte[idx] = value;
	endtask

	task automatic set_patterns(input logic [7:0] p00, input logic [7:0] p01,
			input logic [7:0] p10, input logic [7:0] p11);
		write_pattern(REG_PAT_00, p00);
		write_pattern(REG_PAT_01, p01);
		write_pattern(REG_PAT_10, p10);
		write_pattern(REG_PAT_11, p11);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// all bytes back, then let the pipeline settle
	task automatic wait_drained();
		while (spi_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// output checker and watchdog
	always @(posedge clk) begin : spi_check
		spi_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (spi_beats_due.size() == 0) begin
					$error("unexpected transfer: spi_byte %0d last_byte %0d", spi_byte, last_byte);
					fail_count++;
				end else begin
					want = spi_beats_due.pop_front();
					if (spi_byte !== want.spi_byte) begin
						$error("spi_byte: expected %0d, got %0d", want.spi_byte, spi_byte);
						fail_count++;
					end
					if (last_byte !== want.last_byte) begin
						$error("last_byte: expected %0d, got %0d", want.last_byte, last_byte);
						fail_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random stall before each transfer, one long hold on request
	initial begin : spi_sink
		int n;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				n = $urandom_range(0, out_stall_max);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// stimulus: directed table, then random phases with new pattern bytes each
	initial begin : pixel_source
		rgb_t       colors;
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		in_valid   <= 1'b0;
		hue        <= '0;
		sat        <= '0;
		brightness <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_PAT_00;
		cfg_data   <= '0;
		pair_byte = '{PAT_00_RST, PAT_01_RST, PAT_10_RST, PAT_11_RST};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset patterns
		foreach (pixel_rows[i]) begin
			colors = pixel_rows[i].known ? pixel_rows[i].colors :
				hsv_to_grb(pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].brightness);
			send_pixel(pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].brightness,
				colors, $urandom_range(0, in_gap_max));
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			in_gap_max    = 5;
			out_stall_max = 5;
			case (p)
				0: set_patterns(8'h00, 8'h00, 8'h00, 8'h00);
				1: begin
					// back-to-back pixels into a long receiver hold
					set_patterns(8'hFF, 8'hFF, 8'hFF, 8'hFF);
					in_gap_max    = 0;
					out_stall_max = 0;
					hold_req      = 1'b1;
				end
				2: set_patterns(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				3: begin
					set_patterns(PAT_00_RST, PAT_01_RST, PAT_10_RST, PAT_11_RST);
					in_gap_max    = 0;
					out_stall_max = 0;
				end
				4: set_patterns(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				default: set_patterns(8'h01, 8'h02, 8'h40, 8'h80);
			endcase
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// sender pause mid-phase until the block is empty
				if (p == 2 && i == PHASE_PIXELS / 2) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				h = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 7))
					0: s = 8'hFF;
					1: s = 8'h00;
					default: s = 8'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 7))
					0: v = 8'hFF;
					1: v = 8'h00;
					default: v = 8'($urandom_range(0, 255));
				endcase
				send_pixel(h, s, v, hsv_to_grb(h, s, v), $urandom_range(0, in_gap_max));
			end
			in_valid <= 1'b0;
			wait_drained();
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- hsv_pixel_to_led_spi_encoder_top.f -----
hw/rtl/hsvle_pkg.sv
hw/rtl/hsvle_front.sv
hw/rtl/hsvle_fifo.sv
hw/rtl/hsvle_back.sv
hw/rtl/hsv_pixel_to_led_spi_encoder_top.sv
dv/hsv_pixel_to_led_spi_encoder_top_tb.sv
